[src/wrmt_pkg.sv]
// ----------------------------------------------------------------------------
// Watchpoint range match table package
// Shared widths, operation codes and structures of the watchpoint table.
// ----------------------------------------------------------------------------
package wrmt_pkg;

   localparam int ADDR_W  = 32;
   localparam int SPAN_W  = 31;
   localparam int CLASS_W = 2;

   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [SPAN_W-1:0]  span;
      logic [CLASS_W-1:0] cls;
   } entry_type;

   typedef struct packed {
      logic class_eq;
      logic start_eq;
      logic overlap;
   } cmp_result_type;

endpackage

[src/wrmt_entry_store.sv]
// ----------------------------------------------------------------------------
// Watchpoint entry store
// Holds start, span and class of each table entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module wrmt_entry_store #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  wrmt_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_idx,
   output wrmt_pkg::entry_type rd_data
);
   import wrmt_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/wrmt_overlap_cmp.sv]
// ----------------------------------------------------------------------------
// Watchpoint overlap comparator
// Compares one stored entry against the current transaction: class,
// start address and range overlap with wrapped ends.
// ----------------------------------------------------------------------------
module wrmt_overlap_cmp (
   input  wrmt_pkg::entry_type              entry,
   input  logic [wrmt_pkg::ADDR_W-1:0]      op_addr,
   input  logic [wrmt_pkg::ADDR_W-1:0]      op_end,
   input  logic [wrmt_pkg::CLASS_W-1:0]     op_cls,
   output wrmt_pkg::cmp_result_type         result
);
   import wrmt_pkg::*;

   logic [ADDR_W-1:0] entry_end;

   assign entry_end = entry.start + {1'b0, entry.span} - ADDR_W'(1);

   always_comb begin
      result.class_eq = (entry.cls == op_cls);
      result.start_eq = (entry.start == op_addr);
      result.overlap  = (op_addr <= entry_end) && (op_end >= entry.start);
   end

endmodule

[src/watchpoint_range_match_table_unit.sv]
// ----------------------------------------------------------------------------
// Watchpoint range match table
// Table of watch ranges with add, remove by start, and overlap check.
// ----------------------------------------------------------------------------
// A request transaction carries kind, access class, address and span. Check
// reports a hit when the access overlaps a valid entry of the same class,
// add stores the range in the lowest free slot or reports table_full, and
// remove clears every valid entry of that class with a matching start.
// Every request produces exactly one response transaction.
// One comparator walks the entry store one entry per cycle, fed by the
// store's registered read port: each entry is read, then compared, and
// after the last compare the response register is loaded.
// The request side stalls for the whole walk; the next request is taken in
// the cycle after the response is loaded, even while that response waits,
// so no new request is accepted while a walk is in progress.
// If the receiver stalls, the finished result holds in the walk's final
// state until the response register is free.
// Reset clears all valid bits at once and empties the response register;
// stored ranges are only read behind a valid bit.
// ----------------------------------------------------------------------------
module watchpoint_range_match_table_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic                          req_is_write,
   input  logic                          req_is_virtual,
   input  logic [wrmt_pkg::ADDR_W-1:0]   req_address,
   input  logic [wrmt_pkg::SPAN_W-1:0]   req_span_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_table_full
);
   import wrmt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     hit_ff, hit_in;
   logic                     found_ff, found_in;
   logic [1:0]               op_kind_ff;
   logic [CLASS_W-1:0]       op_cls_ff;
   logic [ADDR_W-1:0]        op_addr_ff;
   logic [ADDR_W-1:0]        op_end_ff;
   logic [SPAN_W-1:0]        op_span_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic           req_accept;
   logic           rsp_taken;
   logic           rsp_load;
   logic           wr_en;
   entry_type      wr_data;
   entry_type      rd_data;
   cmp_result_type cmp;
   logic           cur_valid;

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign cur_valid  = valid_ff[rd_idx_ff];

   assign wr_data.start = op_addr_ff;
   assign wr_data.span  = op_span_ff;
   assign wr_data.cls   = op_cls_ff;

   wrmt_entry_store #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (rd_idx_ff),
      .wr_data (wr_data),
      .rd_idx  (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   wrmt_overlap_cmp u_cmp (
      .entry   (rd_data),
      .op_addr (op_addr_ff),
      .op_end  (op_end_ff),
      .op_cls  (op_cls_ff),
      .result  (cmp)
   );

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      rd_pend_in  = 1'b0;
      rd_idx_in   = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            rd_pend_in  = 1'b1;
            rd_idx_in   = scan_idx_ff[IDX_W-1:0];
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      hit_in   = hit_ff;
      found_in = found_ff;
      wr_en    = 1'b0;
      if (req_accept) begin
         hit_in   = 1'b0;
         found_in = 1'b0;
      end else if (rd_pend_ff) begin
         unique case (op_kind_ff)
            KIND_CHECK: begin
               if (cur_valid && cmp.class_eq && cmp.overlap) begin
                  hit_in = 1'b1;
               end
            end
            KIND_ADD: begin
               if (!cur_valid && !found_ff) begin
                  found_in            = 1'b1;
                  wr_en               = 1'b1;
                  valid_in[rd_idx_ff] = 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (cur_valid && cmp.class_eq && cmp.start_eq) begin
                  valid_in[rd_idx_ff] = 1'b0;
               end
            end
            default: begin
               hit_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff && (op_kind_ff == KIND_CHECK);
         rsp_full_in  = !found_ff && (op_kind_ff == KIND_ADD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_full_ff <= rsp_full_in;
      if (req_accept) begin
         op_kind_ff <= req_kind;
         op_cls_ff  <= {req_is_write, req_is_virtual};
         op_addr_ff <= req_address;
         op_span_ff <= req_span_length;
         op_end_ff  <= req_address + {1'b0, req_span_length} - ADDR_W'(1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_table_full = rsp_full_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("Accepted transaction did not start a table walk.");

   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))
      else $error("Compare stage active outside the table walk.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= LAST_IDX))
      else $error("Walk index ran past the last entry.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_full_ff))
      else $error("Response reports both hit and table full.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("Finished walk did not load the response register.");

endmodule
